>>> rtl/cle_pkg.sv
// Package for the circular list engine: transaction types, command and status codes.
package cle_pkg;

    localparam logic [2:0] CMD_INS_FRONT = 3'd0;
    localparam logic [2:0] CMD_INS_END   = 3'd1;
    localparam logic [2:0] CMD_INS_KEY   = 3'd2;
    localparam logic [2:0] CMD_DEL_FRONT = 3'd3;
    localparam logic [2:0] CMD_DEL_END   = 3'd4;
    localparam logic [2:0] CMD_DEL_KEY   = 3'd5;
    localparam logic [2:0] CMD_READ_ALL  = 3'd6;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [31:0] value;
        logic signed [31:0] key;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] item;
        logic [1:0]         status;
        logic               last;
        logic [4:0]         occupancy;
    } t_out_item;

    typedef struct packed {
        logic      valid;
        t_out_item data;
    } t_res_push;

endpackage

>>> rtl/cle_mem.sv
// Entry store: one write port and one read port with registered read data.
module cle_mem #(
    parameter int unsigned DEPTH = 16,
    parameter int unsigned AW    = 4
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  logic signed [31:0] i_wdata,
    input  logic               i_re,
    input  logic [AW-1:0]      i_raddr,
    output logic signed [31:0] o_rdata
);

    logic signed [31:0] r_mem [DEPTH];
    logic signed [31:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/cle_ctrl.sv
// Command sequencer: head pointer, fill count, key search and entry shifting.
module cle_ctrl #(
    parameter int unsigned CAPACITY = 16,
    parameter int unsigned AW       = 4,
    parameter int unsigned CW       = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  cle_pkg::t_in_item  i_in_data,
    output logic               o_in_ready,
    output cle_pkg::t_res_push o_res,
    input  logic               i_res_ready,
    output logic               o_mem_we,
    output logic [AW-1:0]      o_mem_waddr,
    output logic signed [31:0] o_mem_wdata,
    output logic               o_mem_re,
    output logic [AW-1:0]      o_mem_raddr,
    input  logic signed [31:0] i_mem_rdata
);

    typedef enum logic [9:0] {
        S_IDLE     = 10'b0000000001,
        S_EXEC     = 10'b0000000010,
        S_SRCH_RD  = 10'b0000000100,
        S_SRCH_CMP = 10'b0000001000,
        S_SHIFT_RD = 10'b0000010000,
        S_SHIFT_WR = 10'b0000100000,
        S_PUT      = 10'b0001000000,
        S_RALL_RD  = 10'b0010000000,
        S_RALL_OUT = 10'b0100000000,
        S_DONE     = 10'b1000000000
    } t_state;

    t_state             r_state, n_state;
    logic [2:0]         r_cmd, n_cmd;
    logic signed [31:0] r_value, n_value;
    logic signed [31:0] r_key, n_key;
    logic [AW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_count, n_count;
    logic [CW-1:0]      r_idx, n_idx;
    logic [CW-1:0]      r_pos, n_pos;
    logic [1:0]         r_status, n_status;

    logic               full, empty, idx_last;
    logic [AW-1:0]      head_dec, head_inc;
    logic [CW-1:0]      rd_lidx, wr_lidx;
    logic               wr_front;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] head,
                                             input logic [CW-1:0] lidx);
        logic [CW:0] sum;
        sum = (CW+1)'(head) + (CW+1)'(lidx);
        if (sum >= (CW+1)'(CAPACITY)) begin
            sum = sum - (CW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign full     = (r_count == CW'(CAPACITY));
    assign empty    = (r_count == '0);
    assign idx_last = ((r_idx + CW'(1)) == r_count);
    assign head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_mem_waddr = wr_front ? head_dec : f_phys(r_head, wr_lidx);
    assign o_mem_raddr = f_phys(r_head, rd_lidx);

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_value     = r_value;
        n_key       = r_key;
        n_head      = r_head;
        n_count     = r_count;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_status    = r_status;
        o_mem_we    = 1'b0;
        o_mem_wdata = r_value;
        o_mem_re    = 1'b0;
        rd_lidx     = r_idx;
        wr_lidx     = r_idx;
        wr_front    = 1'b0;
        o_res       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cmd   = i_in_data.command;
                    n_value = i_in_data.value;
                    n_key   = i_in_data.key;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_status = cle_pkg::ST_OK;
                n_idx    = '0;
                n_state  = S_DONE;
                case (r_cmd)
                    cle_pkg::CMD_INS_FRONT: begin
                        if (full) begin
                            n_status = cle_pkg::ST_FULL;
                        end else begin
                            o_mem_we = 1'b1;
                            wr_front = 1'b1;
                            n_head   = head_dec;
                            n_count  = r_count + CW'(1);
                        end
                    end
                    cle_pkg::CMD_INS_END: begin
                        if (full) begin
                            n_status = cle_pkg::ST_FULL;
                        end else begin
                            o_mem_we = 1'b1;
                            wr_lidx  = r_count;
                            n_count  = r_count + CW'(1);
                        end
                    end
                    cle_pkg::CMD_INS_KEY: begin
                        if (empty) begin
                            n_status = cle_pkg::ST_EMPTY;
                        end else if (full) begin
                            n_status = cle_pkg::ST_FULL;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    cle_pkg::CMD_DEL_FRONT: begin
                        if (empty) begin
                            n_status = cle_pkg::ST_EMPTY;
                        end else begin
                            n_head  = head_inc;
                            n_count = r_count - CW'(1);
                        end
                    end
                    cle_pkg::CMD_DEL_END: begin
                        if (empty) begin
                            n_status = cle_pkg::ST_EMPTY;
                        end else begin
                            n_count = r_count - CW'(1);
                        end
                    end
                    cle_pkg::CMD_DEL_KEY: begin
                        if (empty) begin
                            n_status = cle_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_SRCH_RD;
                        end
                    end
                    cle_pkg::CMD_READ_ALL: begin
                        if (empty) begin
                            n_status = cle_pkg::ST_EMPTY;
                        end else begin
                            n_state = S_RALL_RD;
                        end
                    end
                    default: begin
                        n_status = cle_pkg::ST_OK;
                    end
                endcase
            end
            S_SRCH_RD: begin
                o_mem_re = 1'b1;
                n_state  = S_SRCH_CMP;
            end
            S_SRCH_CMP: begin
                if (i_mem_rdata == r_key) begin
                    n_pos = r_idx;
                    if (r_cmd == cle_pkg::CMD_INS_KEY) begin
                        n_idx   = r_count - CW'(1);
                        n_state = S_SHIFT_RD;
                    end else if (idx_last) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SHIFT_RD;
                    end
                end else if (idx_last) begin
                    n_status = cle_pkg::ST_MISSING;
                    n_state  = S_DONE;
                end else begin
                    n_idx   = r_idx + CW'(1);
                    n_state = S_SRCH_RD;
                end
            end
            S_SHIFT_RD: begin
                o_mem_re = 1'b1;
                rd_lidx  = (r_cmd == cle_pkg::CMD_INS_KEY) ? r_idx : r_idx + CW'(1);
                n_state  = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                o_mem_we    = 1'b1;
                o_mem_wdata = i_mem_rdata;
                if (r_cmd == cle_pkg::CMD_INS_KEY) begin
                    wr_lidx = r_idx + CW'(1);
                    if (r_idx == r_pos) begin
                        n_state = S_PUT;
                    end else begin
                        n_idx   = r_idx - CW'(1);
                        n_state = S_SHIFT_RD;
                    end
                end else begin
                    wr_lidx = r_idx;
                    if ((r_idx + CW'(2)) == r_count) begin
                        n_count = r_count - CW'(1);
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_SHIFT_RD;
                    end
                end
            end
            S_PUT: begin
                o_mem_we = 1'b1;
                wr_lidx  = r_pos;
                n_count  = r_count + CW'(1);
                n_state  = S_DONE;
            end
            S_RALL_RD: begin
                o_mem_re = 1'b1;
                n_state  = S_RALL_OUT;
            end
            S_RALL_OUT: begin
                o_res.valid          = 1'b1;
                o_res.data.item      = i_mem_rdata;
                o_res.data.status    = cle_pkg::ST_OK;
                o_res.data.last      = idx_last;
                o_res.data.occupancy = 5'(r_count);
                if (i_res_ready) begin
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + CW'(1);
                        n_state = S_RALL_RD;
                    end
                end
            end
            S_DONE: begin
                o_res.valid          = 1'b1;
                o_res.data.item      = '0;
                o_res.data.status    = r_status;
                o_res.data.last      = 1'b1;
                o_res.data.occupancy = 5'(r_count);
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_idx    <= '0;
            r_pos    <= '0;
            r_status <= cle_pkg::ST_OK;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_status <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_value <= n_value;
        r_key   <= n_key;
    end

endmodule

>>> rtl/circular_list_engine.sv
// Top level of the circular list engine: sequencer, entry store and result register.
//
//  Channel  Valid        Ready        Payload                 Direction
//  input    i_in_valid   o_in_ready   i_in_data  (t_in_item)  into the block
//  result   o_out_valid  i_out_ready  o_out_data (t_out_item) out of the block
//
// Front or end commands pass from acceptance through an execute state to the result state.
// A key search visits entries one at a time, as each probe is a registered read of the
// store followed by a compare; shifting reads and then writes each entry moved.
// Read all reads each entry from the store before presenting it as a result. Reset clears
// the head pointer, fill count and sequencer state.
// A full result register stalls the sequencer until the transaction is taken.
module circular_list_engine #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  cle_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output cle_pkg::t_out_item  o_out_data
);

    localparam int unsigned AW = $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    cle_pkg::t_res_push res;
    logic               res_ready;
    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic signed [31:0] mem_wdata, mem_rdata;

    logic               r_out_valid;
    cle_pkg::t_out_item r_out_data;

    assign res_ready = !r_out_valid || i_out_ready;

    cle_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW),
        .CW       (CW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_ready  (o_in_ready),
        .o_res       (res),
        .i_res_ready (res_ready),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_re    (mem_re),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    cle_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res.valid) begin
            r_out_data <= res.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
